FILE: hw/rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Request/result beat layouts, pool and bucket sizes, command and status codes.
// ----------------------------------------------------------------------------
`default_nettype none
package chte_pkg;

  localparam int BUCKETS = 256;
  localparam int POOL    = 1024;
  localparam int B_W     = $clog2(BUCKETS);
  localparam int NODE_W  = $clog2(POOL);
  localparam int LINK_W  = NODE_W + 1;
  localparam int CNT_W   = 9;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL);

  localparam logic [1:0] CMD_PUT = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;
  localparam logic [1:0] CMD_GOC = 2'd3;

  localparam logic [2:0] ST_CREATED = 3'd0;
  localparam logic [2:0] ST_FOUND   = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_DELMISS = 3'd4;
  localparam logic [2:0] ST_BADBKT  = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic        use_bucket;
    logic [15:0] bucket;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_res;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/chte_mod.sv
// ----------------------------------------------------------------------------
// chte_mod: iterative key modulo bucket count
// Restoring remainder, two dividend bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module chte_mod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [31:0]                dividend,
  input  wire logic [chte_pkg::CNT_W-1:0] divisor,
  output logic                            done,
  output logic [chte_pkg::B_W-1:0]        rem
);
  import chte_pkg::*;

  logic [31:0]    shreg;
  logic [3:0]     cnt;
  logic           run;
  logic [B_W-1:0] r1, r2;

  // one restoring step: shift in a bit, subtract when not below the divisor
  function automatic logic [B_W-1:0] step(input logic [B_W-1:0] r, input logic b,
                                          input logic [CNT_W-1:0] d);
    logic [CNT_W-1:0] t;
    t = {r, b};
    if (t >= d) t = t - d;
    return t[B_W-1:0];
  endfunction

  always_comb begin
    r1 = step(rem, shreg[31], divisor);
    r2 = step(r1, shreg[30], divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        rem   <= '0;
      end else if (run) begin
        rem   <= r2;
        shreg <= {shreg[29:0], 2'b00};
        cnt   <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/chained_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top: key/value table with separate chaining
// Sequencer walks bucket chains in node memories; freed nodes go to a free list.
// ----------------------------------------------------------------------------
// channel   | handshake        | payload
// request   | start & !busy    | req  (cmd, key, value, use_bucket, bucket)
// result    | done (1 cycle)   | res  (status, value_res)
// config    | cfg_we           | cfg_data (bucket_count)
//
// A request passes the modulo state (launch, two-bit steps, done seen),
// skipped with a given bucket, then head read (S_HEAD, S_HWAIT), a check and
// a compare per chain node, one more check to see the chain end on a miss,
// then the update states and S_OUT. A bad given bucket reports in the cycle
// after accept. The registered-read node memories set the walk.
// Reset clears bucket head valid bits at once; no clearing pass.
// The result beat cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_table_engine_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire chte_pkg::req_t             req,
  input  wire logic                       cfg_we,
  input  wire logic [chte_pkg::CNT_W-1:0] cfg_data,
  output logic                            done,
  output chte_pkg::res_t                  res
);
  import chte_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_HEAD  = 4'd2;
  localparam logic [3:0] S_HWAIT = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_ACT   = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_NEW   = 4'd8;
  localparam logic [3:0] S_DEL2  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]        state;
  logic [CNT_W-1:0]  bucket_count, cnt_eff;
  req_t              r;
  logic [B_W-1:0]    b;
  logic [LINK_W-1:0] node, prev, head_node, free_top, fresh, new_node;
  logic              hit;
  logic [31:0]       hit_val;
  logic [LINK_W-1:0] hit_link;
  logic [2:0]        status_r;
  logic [31:0]       res_r;

  // modulo unit
  logic           mod_start, mod_done;
  logic [B_W-1:0] mod_rem;

  // memories
  logic [31:0]       mem_key  [POOL];
  logic [31:0]       mem_val  [POOL];
  logic [LINK_W-1:0] mem_link [POOL];
  logic [LINK_W-1:0] mem_head [BUCKETS];
  logic [BUCKETS-1:0] head_v;
  logic [31:0]       key_q, val_q;
  logic [LINK_W-1:0] link_q, head_q;
  logic              hv_q;
  logic [NODE_W-1:0] rd_addr, wr_addr;
  logic              we_key, we_val, we_link, we_head;
  logic [31:0]       wd_key, wd_val;
  logic [LINK_W-1:0] wd_link, wd_head;

  // effective bucket count
  always_comb begin
    cnt_eff = bucket_count;
    if (bucket_count == '0) cnt_eff = CNT_W'(1);
    if (bucket_count > CNT_W'(BUCKETS)) cnt_eff = CNT_W'(BUCKETS);
  end

  chte_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (r.key),
    .divisor  (cnt_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_OUT);
  assign res       = '{status: status_r, value_res: res_r};
  assign mod_start = (state == S_MOD) && !mod_done && (status_r == ST_BADBKT) == 1'b0
                     && (r.use_bucket == 1'b0) && (prev == NIL) && (node == '0);

  // memory control per state
  always_comb begin
    rd_addr = node[NODE_W-1:0];
    wr_addr = node[NODE_W-1:0];
    we_key  = 1'b0;
    we_val  = 1'b0;
    we_link = 1'b0;
    we_head = 1'b0;
    wd_key  = r.key;
    wd_val  = r.value;
    wd_link = hit_link;
    wd_head = hit_link;
    unique case (state)
      S_ACT: begin
        rd_addr = free_top[NODE_W-1:0];
        if (hit && r.cmd == CMD_DEL) begin
          if (prev != NIL) begin
            wr_addr = prev[NODE_W-1:0];
            we_link = 1'b1;
          end else begin
            we_head = 1'b1;
          end
        end else if (hit && r.cmd == CMD_PUT) begin
          we_val = 1'b1;
        end
      end
      S_NEW: begin
        wr_addr = new_node[NODE_W-1:0];
        we_key  = 1'b1;
        we_val  = 1'b1;
        we_link = 1'b1;
        we_head = 1'b1;
        wd_val  = (r.cmd == CMD_PUT) ? r.value : 32'd0;
        wd_link = head_node;
        wd_head = new_node;
      end
      S_DEL2: begin
        we_link = 1'b1;
        wd_link = free_top;
      end
      default: ;
    endcase
  end

  // node memories, registered read
  always_ff @(posedge clk) begin
    if (we_key)  mem_key[wr_addr]  <= wd_key;
    if (we_val)  mem_val[wr_addr]  <= wd_val;
    if (we_link) mem_link[wr_addr] <= wd_link;
    key_q  <= mem_key[rd_addr];
    val_q  <= mem_val[rd_addr];
    link_q <= mem_link[rd_addr];
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (we_head) mem_head[b] <= wd_head;
    head_q <= mem_head[b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_v <= '0;
      hv_q   <= 1'b0;
    end else begin
      if (we_head) head_v[b] <= 1'b1;
      hv_q <= head_v[b];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= CNT_W'(256);
      free_top     <= NIL;
      fresh        <= '0;
      status_r     <= '0;
      res_r        <= '0;
      node         <= '0;
      prev         <= NIL;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r        <= req;
            node     <= '0;
            prev     <= NIL;
            status_r <= ST_FOUND;
            res_r    <= '0;
            if (req.use_bucket) begin
              if (req.bucket >= 16'(cnt_eff)) begin
                status_r <= ST_BADBKT;
                state    <= S_OUT;
              end else begin
                b     <= req.bucket[B_W-1:0];
                state <= S_HEAD;
              end
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          prev <= LINK_W'(0);
          if (mod_done) begin
            b     <= mod_rem;
            state <= S_HEAD;
          end
        end
        S_HEAD: state <= S_HWAIT;
        S_HWAIT: begin
          node      <= hv_q ? head_q : NIL;
          head_node <= hv_q ? head_q : NIL;
          prev      <= NIL;
          hit       <= 1'b0;
          state     <= S_CHK;
        end
        S_CHK: begin
          if (node == NIL) state <= S_ACT;
          else state <= S_CMP;
        end
        S_CMP: begin
          if (key_q == r.key) begin
            hit      <= 1'b1;
            hit_val  <= val_q;
            hit_link <= link_q;
            state    <= S_ACT;
          end else begin
            prev  <= node;
            node  <= link_q;
            state <= S_CHK;
          end
        end
        S_ACT: begin
          state <= S_OUT;
          unique case (r.cmd)
            CMD_GET: begin
              status_r <= hit ? ST_FOUND : ST_ABSENT;
              res_r    <= hit ? hit_val : 32'd0;
            end
            CMD_DEL: begin
              if (hit) begin
                status_r <= ST_REMOVED;
                res_r    <= hit_val;
                state    <= S_DEL2;
              end else begin
                status_r <= ST_DELMISS;
              end
            end
            default: begin
              if (hit) begin
                status_r <= ST_FOUND;
                res_r    <= (r.cmd == CMD_PUT) ? r.value : hit_val;
              end else if (free_top != NIL) begin
                state <= S_ALLOC;
              end else if (fresh != LINK_W'(POOL)) begin
                new_node <= fresh;
                fresh    <= fresh + LINK_W'(1);
                state    <= S_NEW;
              end else begin
                status_r <= ST_FULL;
              end
            end
          endcase
        end
        S_ALLOC: begin
          new_node <= free_top;
          free_top <= link_q;
          state    <= S_NEW;
        end
        S_NEW: begin
          status_r <= ST_CREATED;
          res_r    <= (r.cmd == CMD_PUT) ? r.value : 32'd0;
          state    <= S_OUT;
        end
        S_DEL2: begin
          free_top <= node;
          state    <= S_OUT;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
